>>> hw/rtl/ddo_pkg.sv
// Shared types, constants and tables for the wheel odometry core.
package ddo_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_LEFT_DPT  = 2'd0;
    localparam logic [1:0] REG_RIGHT_DPT = 2'd1;
    localparam logic [1:0] REG_INV_BASE  = 2'd2;

    localparam logic [23:0] LEFT_DPT_RESET  = 24'd531784;
    localparam logic [23:0] RIGHT_DPT_RESET = 24'd502240;
    localparam logic [23:0] INV_BASE_RESET  = 24'd309130;

    localparam logic [31:0] TURN_PER_RAD = 32'd683565276;
    localparam logic [31:0] US_PER_S     = 32'd1000000;
    localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic [23:0]        elapsed_us;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] lin_vel;
        logic signed [31:0] ang_vel;
        logic               zero_interval;
    } out_t;

    typedef enum logic [3:0] {
        MUL_NONE = 4'd0,
        MUL_DL   = 4'd1,
        MUL_DR   = 4'd2,
        MUL_RLO  = 4'd3,
        MUL_RHI  = 4'd4,
        MUL_ULO  = 4'd5,
        MUL_UHI  = 4'd6,
        MUL_XLO  = 4'd7,
        MUL_XHI  = 4'd8,
        MUL_YLO  = 4'd9,
        MUL_YHI  = 4'd10,
        MUL_VLO  = 4'd11,
        MUL_VHI  = 4'd12
    } mul_sel_t;

    typedef enum logic [3:0] {
        TAKE_NONE = 4'd0,
        TAKE_DL   = 4'd1,
        TAKE_DR   = 4'd2,
        TAKE_SD   = 4'd3,
        TAKE_RLO  = 4'd4,
        TAKE_RHI  = 4'd5,
        TAKE_ULO  = 4'd6,
        TAKE_UHI  = 4'd7,
        TAKE_XLO  = 4'd8,
        TAKE_XHI  = 4'd9,
        TAKE_YLO  = 4'd10,
        TAKE_YHI  = 4'd11,
        TAKE_VLO  = 4'd12,
        TAKE_VHI  = 4'd13
    } take_sel_t;

    typedef struct packed {
        logic       capture;
        mul_sel_t   mul_sel;
        take_sel_t  take_sel;
        logic       cordic_init;
        logic       cordic_step;
        logic       cordic_fin;
        logic [4:0] iter;
        logic       pass2;
        logic       div_step;
        logic       div_fin;
        logic       vel_ang;
        logic       load_out;
    } cmd_t;

    // Arctangent of 2^-i as a binary angle
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/ddo_ctrl.sv
// Sequencer for the odometry datapath: one request at a time.
module ddo_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output ddo_pkg::cmd_t cmd
);

    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [5:0] CORDIC_LAST = 6'(STEPS - 1);
    localparam logic [5:0] DIV_LAST    = 6'd63;

    typedef enum logic [24:0] {
        S_IDLE  = 25'b1 << 0,
        S_M_L   = 25'b1 << 1,
        S_M_R   = 25'b1 << 2,
        S_T_R   = 25'b1 << 3,
        S_SD    = 25'b1 << 4,
        S_R_LO  = 25'b1 << 5,
        S_R_HI  = 25'b1 << 6,
        S_T_RH  = 25'b1 << 7,
        S_U_LO  = 25'b1 << 8,
        S_U_HI  = 25'b1 << 9,
        S_T_UH  = 25'b1 << 10,
        S_C_INIT = 25'b1 << 11,
        S_C_ITER = 25'b1 << 12,
        S_C_FIN = 25'b1 << 13,
        S_X_LO  = 25'b1 << 14,
        S_X_HI  = 25'b1 << 15,
        S_Y_LO  = 25'b1 << 16,
        S_Y_HI  = 25'b1 << 17,
        S_T_YH  = 25'b1 << 18,
        S_V_LO  = 25'b1 << 19,
        S_V_HI  = 25'b1 << 20,
        S_T_VH  = 25'b1 << 21,
        S_D_ITER = 25'b1 << 22,
        S_D_FIN = 25'b1 << 23,
        S_OUT   = 25'b1 << 24
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       pass2_reg, pass2_next;
    logic       ang_reg, ang_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pass2_next     = pass2_reg;
        ang_next       = ang_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        cmd             = '0;
        cmd.mul_sel     = ddo_pkg::MUL_NONE;
        cmd.take_sel    = ddo_pkg::TAKE_NONE;
        cmd.iter        = cnt_reg[4:0];
        cmd.pass2       = pass2_reg;
        cmd.vel_ang     = ang_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    pass2_next  = 1'b0;
                    ang_next    = 1'b0;
                    state_next  = S_M_L;
                end
            end
            S_M_L:
            begin
                cmd.mul_sel = ddo_pkg::MUL_DL;
                state_next  = S_M_R;
            end
            S_M_R:
            begin
                cmd.mul_sel  = ddo_pkg::MUL_DR;
                cmd.take_sel = ddo_pkg::TAKE_DL;
                state_next   = S_T_R;
            end
            S_T_R:
            begin
                cmd.take_sel = ddo_pkg::TAKE_DR;
                state_next   = S_SD;
            end
            S_SD:
            begin
                cmd.take_sel = ddo_pkg::TAKE_SD;
                state_next   = S_R_LO;
            end
            S_R_LO:
            begin
                cmd.mul_sel = ddo_pkg::MUL_RLO;
                state_next  = S_R_HI;
            end
            S_R_HI:
            begin
                cmd.mul_sel  = ddo_pkg::MUL_RHI;
                cmd.take_sel = ddo_pkg::TAKE_RLO;
                state_next   = S_T_RH;
            end
            S_T_RH:
            begin
                cmd.take_sel = ddo_pkg::TAKE_RHI;
                state_next   = S_U_LO;
            end
            S_U_LO:
            begin
                cmd.mul_sel = ddo_pkg::MUL_ULO;
                state_next  = S_U_HI;
            end
            S_U_HI:
            begin
                cmd.mul_sel  = ddo_pkg::MUL_UHI;
                cmd.take_sel = ddo_pkg::TAKE_ULO;
                state_next   = S_T_UH;
            end
            S_T_UH:
            begin
                cmd.take_sel = ddo_pkg::TAKE_UHI;
                state_next   = S_C_INIT;
            end
            S_C_INIT:
            begin
                cmd.cordic_init = 1'b1;
                cnt_next        = '0;
                state_next      = S_C_ITER;
            end
            S_C_ITER:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 6'd1;
                if (cnt_reg == CORDIC_LAST)
                begin
                    state_next = S_C_FIN;
                end
            end
            S_C_FIN:
            begin
                cmd.cordic_fin = 1'b1;
                state_next     = pass2_reg ? S_V_LO : S_X_LO;
            end
            S_X_LO:
            begin
                cmd.mul_sel = ddo_pkg::MUL_XLO;
                state_next  = S_X_HI;
            end
            S_X_HI:
            begin
                cmd.mul_sel  = ddo_pkg::MUL_XHI;
                cmd.take_sel = ddo_pkg::TAKE_XLO;
                state_next   = S_Y_LO;
            end
            S_Y_LO:
            begin
                cmd.mul_sel  = ddo_pkg::MUL_YLO;
                cmd.take_sel = ddo_pkg::TAKE_XHI;
                state_next   = S_Y_HI;
            end
            S_Y_HI:
            begin
                cmd.mul_sel  = ddo_pkg::MUL_YHI;
                cmd.take_sel = ddo_pkg::TAKE_YLO;
                state_next   = S_T_YH;
            end
            S_T_YH:
            begin
                cmd.take_sel = ddo_pkg::TAKE_YHI;
                pass2_next   = 1'b1;
                state_next   = S_C_INIT;
            end
            S_V_LO:
            begin
                cmd.mul_sel = ddo_pkg::MUL_VLO;
                state_next  = S_V_HI;
            end
            S_V_HI:
            begin
                cmd.mul_sel  = ddo_pkg::MUL_VHI;
                cmd.take_sel = ddo_pkg::TAKE_VLO;
                state_next   = S_T_VH;
            end
            S_T_VH:
            begin
                cmd.take_sel = ddo_pkg::TAKE_VHI;
                cnt_next     = '0;
                state_next   = S_D_ITER;
            end
            S_D_ITER:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_D_FIN;
                end
            end
            S_D_FIN:
            begin
                cmd.div_fin = 1'b1;
                if (ang_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ang_next   = 1'b1;
                    state_next = S_V_LO;
                end
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pass2_reg     <= 1'b0;
            ang_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pass2_reg     <= pass2_next;
            ang_reg       <= ang_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/ddo_dp.sv
// Odometry datapath: shared multiplier, CORDIC step, serial divider and state.
module ddo_dp #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    input  ddo_pkg::in_t  in_data,
    input  ddo_pkg::cmd_t cmd,
    output ddo_pkg::out_t out_data
);

    localparam int SHIFT = 31 - POS_FRAC_BITS;

    logic [23:0] ldpt_reg, rdpt_reg, iwb_reg;
    logic [31:0] prev_l_reg, prev_r_reg, heading_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;

    logic [23:0] us_reg;
    logic [31:0] dl_mag_reg, dr_mag_reg;
    logic        dl_neg_reg, dr_neg_reg;
    logic signed [57:0] dl_reg, dr_reg;
    logic [57:0] ms_reg, dm_reg;
    logic        sum_neg_reg, diff_neg_reg;
    logic [63:0] rad_reg, p_reg, div_n_reg;
    logic [31:0] lo_reg, dturn_reg;
    logic        cap_reg;
    logic [23:0] rem_reg;

    logic signed [35:0] cx_reg, cy_reg, c_reg, s_reg;
    logic signed [33:0] cz_reg;
    logic        flip_reg;
    logic signed [15:0] qz_reg, qw_reg;
    logic signed [31:0] lin_reg, ang_reg;
    ddo_pkg::out_t out_reg;

    assign out_data = out_reg;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                  input logic [63:0] mag,
                                                  input logic neg);
        logic signed [65:0] s;
        logic signed [65:0] d;
        logic signed [31:0] r;
        d = $signed({2'b00, mag});
        s = $signed({{34{acc[31]}}, acc}) + (neg ? -d : d);
        if (s > 66'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (s < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] clamp_q14(input logic signed [35:0] v);
        logic signed [35:0] t;
        logic signed [15:0] r;
        t = v >>> 16;
        if (t > 36'sd16384)
            r = 16'sd16384;
        else if (t < -36'sd16384)
            r = -16'sd16384;
        else
            r = t[15:0];
        return r;
    endfunction

    // Multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic [35:0] c_mag, s_mag;
    logic [47:0] q16;

    assign c_mag = c_reg[35] ? 36'(-c_reg) : 36'(c_reg);
    assign s_mag = s_reg[35] ? 36'(-s_reg) : 36'(s_reg);
    assign q16   = cmd.vel_ang ? rad_reg[63:16] : {7'b0, ms_reg[57:17]};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            ddo_pkg::MUL_DL:  begin mul_a = dl_mag_reg;            mul_b = {8'b0, ldpt_reg}; end
            ddo_pkg::MUL_DR:  begin mul_a = dr_mag_reg;            mul_b = {8'b0, rdpt_reg}; end
            ddo_pkg::MUL_RLO: begin mul_a = dm_reg[31:0];          mul_b = {8'b0, iwb_reg};  end
            ddo_pkg::MUL_RHI: begin mul_a = {6'b0, dm_reg[57:32]}; mul_b = {8'b0, iwb_reg};  end
            ddo_pkg::MUL_ULO: begin mul_a = rad_reg[31:0];  mul_b = ddo_pkg::TURN_PER_RAD; end
            ddo_pkg::MUL_UHI: begin mul_a = rad_reg[63:32]; mul_b = ddo_pkg::TURN_PER_RAD; end
            ddo_pkg::MUL_XLO: begin mul_a = ms_reg[31:0];          mul_b = c_mag[31:0]; end
            ddo_pkg::MUL_XHI: begin mul_a = {6'b0, ms_reg[57:32]}; mul_b = c_mag[31:0]; end
            ddo_pkg::MUL_YLO: begin mul_a = ms_reg[31:0];          mul_b = s_mag[31:0]; end
            ddo_pkg::MUL_YHI: begin mul_a = {6'b0, ms_reg[57:32]}; mul_b = s_mag[31:0]; end
            ddo_pkg::MUL_VLO: begin mul_a = q16[31:0];            mul_b = ddo_pkg::US_PER_S; end
            ddo_pkg::MUL_VHI: begin mul_a = {16'b0, q16[47:32]}; mul_b = ddo_pkg::US_PER_S; end
            default:          begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Working values for the take operations
    logic [31:0] d_l, d_r;
    logic signed [57:0] sum_w, diff_w;
    logic [31:0] turn_w;
    logic [63:0] pr_w;
    logic [31:0] ang_in;
    logic [31:0] ang_chk;
    logic [35:0] at_w;
    logic signed [35:0] fx, fy;
    logic [24:0] r2;
    logic        ge;
    logic [63:0] v_mag;
    logic [31:0] v_sat;
    logic        v_neg;
    logic signed [31:0] v_out;

    always_comb
    begin
        d_l     = in_data.left_count - prev_l_reg;
        d_r     = in_data.right_count - prev_r_reg;
        sum_w   = dl_reg + dr_reg;
        diff_w  = dr_reg - dl_reg;
        turn_w  = p_reg[31:0] + lo_reg;
        pr_w    = p_reg + {32'b0, lo_reg};
        ang_in  = cmd.pass2 ? {1'b0, heading_reg[31:1]} : heading_reg;
        ang_chk = ang_in + 32'h40000000;
        at_w    = {4'b0, ddo_pkg::atan_turn(cmd.iter)};
        fx      = flip_reg ? -cx_reg : cx_reg;
        fy      = flip_reg ? -cy_reg : cy_reg;
        r2      = {rem_reg, div_n_reg[63]};
        ge      = (r2 >= {1'b0, us_reg});
        v_mag   = cap_reg ? 64'h0000_0100_0000_0000 : div_n_reg;
        v_neg   = cmd.vel_ang ? diff_neg_reg : sum_neg_reg;
        if (!v_neg && (|v_mag[63:31]))
            v_sat = 32'h7FFFFFFF;
        else if (v_neg && ((|v_mag[63:32]) || (v_mag[31] && (|v_mag[30:0]))))
            v_sat = 32'h80000000;
        else
            v_sat = v_mag[31:0];
        if (us_reg == '0)
            v_out = '0;
        else
            v_out = v_neg ? $signed(-v_sat) : $signed(v_sat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ldpt_reg    <= ddo_pkg::LEFT_DPT_RESET;
            rdpt_reg    <= ddo_pkg::RIGHT_DPT_RESET;
            iwb_reg     <= ddo_pkg::INV_BASE_RESET;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            heading_reg <= '0;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    ddo_pkg::REG_LEFT_DPT:  ldpt_reg <= cfg_data;
                    ddo_pkg::REG_RIGHT_DPT: rdpt_reg <= cfg_data;
                    ddo_pkg::REG_INV_BASE:  iwb_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.capture)
            begin
                prev_l_reg <= in_data.left_count;
                prev_r_reg <= in_data.right_count;
            end
            case (cmd.take_sel)
                ddo_pkg::TAKE_XHI:
                begin
                    acc_x_reg <= sat_add(acc_x_reg, pr_w >> SHIFT, sum_neg_reg ^ c_reg[35]);
                end
                ddo_pkg::TAKE_YHI:
                begin
                    acc_y_reg   <= sat_add(acc_y_reg, pr_w >> SHIFT, sum_neg_reg ^ s_reg[35]);
                    heading_reg <= heading_reg + dturn_reg;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_reg <= 64'(mul_a) * 64'(mul_b);
        if (cmd.capture)
        begin
            us_reg     <= in_data.elapsed_us;
            dl_neg_reg <= d_l[31];
            dr_neg_reg <= d_r[31];
            dl_mag_reg <= d_l[31] ? -d_l : d_l;
            dr_mag_reg <= d_r[31] ? -d_r : d_r;
        end
        case (cmd.take_sel)
            ddo_pkg::TAKE_DL:
                dl_reg <= dl_neg_reg ? -$signed({2'b00, p_reg[55:0]}) : $signed({2'b00, p_reg[55:0]});
            ddo_pkg::TAKE_DR:
                dr_reg <= dr_neg_reg ? -$signed({2'b00, p_reg[55:0]}) : $signed({2'b00, p_reg[55:0]});
            ddo_pkg::TAKE_SD:
            begin
                sum_neg_reg  <= sum_w[57];
                diff_neg_reg <= diff_w[57];
                ms_reg       <= sum_w[57] ? 58'(-sum_w) : 58'(sum_w);
                dm_reg       <= diff_w[57] ? 58'(-diff_w) : 58'(diff_w);
            end
            ddo_pkg::TAKE_RLO: rad_reg <= {16'b0, p_reg[63:16]};
            ddo_pkg::TAKE_RHI: rad_reg <= {p_reg[47:0], 16'b0} + rad_reg;
            ddo_pkg::TAKE_ULO: lo_reg  <= p_reg[63:32];
            ddo_pkg::TAKE_UHI: dturn_reg <= diff_neg_reg ? -turn_w : turn_w;
            ddo_pkg::TAKE_XLO: lo_reg  <= p_reg[63:32];
            ddo_pkg::TAKE_YLO: lo_reg  <= p_reg[63:32];
            ddo_pkg::TAKE_VLO: div_n_reg <= p_reg;
            ddo_pkg::TAKE_VHI:
            begin
                div_n_reg <= div_n_reg + {p_reg[31:0], 32'b0};
                rem_reg   <= '0;
                cap_reg   <= |q16[47:43];
            end
            default: ;
        endcase
        if (cmd.cordic_init)
        begin
            flip_reg <= ang_chk[31];
            cx_reg   <= ddo_pkg::CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= $signed({{2{ang_in[31] ^ ang_chk[31]}},
                                 ang_in[31] ^ ang_chk[31], ang_in[30:0]});
        end
        if (cmd.cordic_step)
        begin
            if (!cz_reg[33])
            begin
                cx_reg <= cx_reg - (cy_reg >>> cmd.iter);
                cy_reg <= cy_reg + (cx_reg >>> cmd.iter);
                cz_reg <= cz_reg - $signed(at_w[33:0]);
            end
            else
            begin
                cx_reg <= cx_reg + (cy_reg >>> cmd.iter);
                cy_reg <= cy_reg - (cx_reg >>> cmd.iter);
                cz_reg <= cz_reg + $signed(at_w[33:0]);
            end
        end
        if (cmd.cordic_fin)
        begin
            if (cmd.pass2)
            begin
                qw_reg <= clamp_q14(fx);
                qz_reg <= clamp_q14(fy);
            end
            else
            begin
                c_reg <= fx;
                s_reg <= fy;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg   <= ge ? 24'(r2 - {1'b0, us_reg}) : r2[23:0];
            div_n_reg <= {div_n_reg[62:0], ge};
        end
        if (cmd.div_fin)
        begin
            if (cmd.vel_ang)
                ang_reg <= v_out;
            else
                lin_reg <= v_out;
        end
        if (cmd.load_out)
        begin
            out_reg.pos_x         <= acc_x_reg;
            out_reg.pos_y         <= acc_y_reg;
            out_reg.heading       <= heading_reg;
            out_reg.quat_z        <= qz_reg;
            out_reg.quat_w        <= qw_reg;
            out_reg.lin_vel       <= lin_reg;
            out_reg.ang_vel       <= ang_reg;
            out_reg.zero_interval <= (us_reg == '0);
        end
    end

endmodule

>>> hw/rtl/diff_drive_wheel_odometry_core.sv
// Top level of the differential-drive wheel odometry core.
// Each request carries both raw encoder counts and the microseconds since the
// previous request. The core takes the count deltas modulo 2^32, scales them
// to wheel distances, advances the position along the old heading (CORDIC
// sin/cos), adds the turn to the heading, and returns position, heading, the
// yaw quaternion and linear and angular velocity. A request runs through two
// CORDIC passes on one shared iteration unit (CORDIC_STEPS capped at 32) and
// two 64-step serial divisions for the velocities, all fed by a single
// registered 32x32 multiplier; the next request is accepted only after the
// result has been loaded into the output register. One request is in work at
// a time; a finished result waits in the output register while the next
// request is accepted.
// Position saturates at the signed 32-bit limits. A zero interval forces both
// velocities to zero and sets zero_interval. Configuration writes are always
// ready and must only be issued while the core is idle; unknown indexes drop.
module diff_drive_wheel_odometry_core #(
    parameter int CORDIC_STEPS  = 16,
    parameter int POS_FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ddo_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ddo_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [23:0]   cfg_data
);

    ddo_pkg::cmd_t cmd;

    // configuration registers never stall
    assign cfg_ready = 1'b1;

    ddo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ddo_dp #(
        .POS_FRAC_BITS(POS_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_data  (out_data)
    );

endmodule

>>> hw/rtl/ddo_checker.sv
// Port-level checks for the odometry core, bound to the top level.
module ddo_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input ddo_pkg::out_t out_data
);

    // a request keeps the core busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("core ready right after accepting a request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    a_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.zero_interval) |->
            (out_data.lin_vel == 32'sd0 && out_data.ang_vel == 32'sd0))
        else $error("velocity not zero on zero interval");

    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.quat_z <= 16'sd16384 && out_data.quat_z >= -16'sd16384 &&
                       out_data.quat_w <= 16'sd16384 && out_data.quat_w >= -16'sd16384))
        else $error("quaternion out of range");

endmodule

bind diff_drive_wheel_odometry_core ddo_checker u_ddo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
